[hw/rtl/srsk_pkg.sv]
// Shared constants for the stable record sorter.
// Default capacity and field widths used by the top level and the record store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srsk_pkg;

    localparam int SRSK_MAX_RECORDS  = 64;
    localparam int SRSK_KEY_BITS     = 8;
    localparam int SRSK_PAYLOAD_BITS = 32;

endpackage : srsk_pkg

`default_nettype wire

[hw/rtl/srsk_store.sv]
// Record store: one write port and one read port, registered read data.
// Holds {key, payload} words for the sorter. Uses srsk_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module srsk_store
    import srsk_pkg::*;
#(
    parameter int DEPTH = SRSK_MAX_RECORDS,
    parameter int WIDTH = SRSK_KEY_BITS + SRSK_PAYLOAD_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule : srsk_store

`default_nettype wire

[hw/rtl/stable_record_sort_by_key.sv]
// Stable record sorter top level: insertion controller, output register.
// Depends on srsk_pkg and srsk_store.
//
//   channel  | direction | ports                                              | handshake
//   request  | in        | s_record_key, s_record_payload, s_batch_end        | s_valid/s_ready
//   result   | out       | m_sorted_key, m_sorted_payload, m_final_result,    | m_valid/m_ready
//            |           | m_overflowed                                       |
//
// Insertion: in ST_SHIFT a request walks down from the tail, shifting greater keys up a
// slot, and is written there or, at the head, in ST_PLACE; the read port walks one entry
// per cycle. A dropped request (store full) or a batch's first request is handled in
// ST_IDLE. After the batch_end request, readout goes via ST_FETCH and ST_LOAD, then one
// result per cycle while m_ready is high; s_ready stays low from a batch_end request until
// the final result is taken. Reset (aresetn low at a clock edge) empties the store.
`timescale 1ns / 1ps
`default_nettype none

module stable_record_sort_by_key
    import srsk_pkg::*;
#(
    parameter int MAX_RECORDS  = SRSK_MAX_RECORDS,
    parameter int KEY_BITS     = SRSK_KEY_BITS,
    parameter int PAYLOAD_BITS = SRSK_PAYLOAD_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [KEY_BITS-1:0]     s_record_key,
    input  wire logic [PAYLOAD_BITS-1:0] s_record_payload,
    input  wire logic                    s_batch_end,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [KEY_BITS-1:0]     m_sorted_key,
    output logic      [PAYLOAD_BITS-1:0] m_sorted_payload,
    output logic                         m_final_result,
    output logic                         m_overflowed
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_FETCH,
        ST_LOAD,
        ST_HOLD
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        emit_idx_reg, emit_idx_next;
    logic [KEY_BITS-1:0]     new_key_reg, new_key_next;
    logic [PAYLOAD_BITS-1:0] new_pay_reg, new_pay_next;
    logic                    new_last_reg, new_last_next;
    logic                    m_valid_reg, m_valid_next;
    logic [KEY_BITS-1:0]     m_key_reg, m_key_next;
    logic [PAYLOAD_BITS-1:0] m_pay_reg, m_pay_next;
    logic                    m_final_reg, m_final_next;
    logic                    m_ovf_reg, m_ovf_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [REC_W-1:0]        wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [REC_W-1:0]        rd_data;

    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [CNT_W-1:0]        cnt_last;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        pos_dec;
    logic [CNT_W-1:0]        pos_dec2;
    logic [CNT_W-1:0]        emit_inc;
    logic                    emit_is_final;

    srsk_store #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (REC_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key        = rd_data[REC_W-1:PAYLOAD_BITS];
    assign rd_pay        = rd_data[PAYLOAD_BITS-1:0];
    assign cnt_last      = count_reg - CNT_W'(1);
    assign cnt_inc       = count_reg + CNT_W'(1);
    assign pos_dec       = pos_reg - CNT_W'(1);
    assign pos_dec2      = pos_reg - CNT_W'(2);
    assign emit_inc      = emit_idx_reg + CNT_W'(1);
    assign emit_is_final = (emit_idx_reg == cnt_last);

    // Next-state and store access control
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        emit_idx_next = emit_idx_reg;
        new_key_next  = new_key_reg;
        new_pay_next  = new_pay_reg;
        new_last_next = new_last_reg;
        m_valid_next  = m_valid_reg;
        m_key_next    = m_key_reg;
        m_pay_next    = m_pay_reg;
        m_final_next  = m_final_reg;
        m_ovf_next    = m_ovf_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (count_reg >= CNT_W'(MAX_RECORDS)) begin
                        // Store full: drop the request, note the overflow
                        ovf_next = 1'b1;
                        if (s_batch_end) begin
                            state_next = ST_FETCH;
                        end
                    end else if (count_reg == '0) begin
                        // Empty store: place at the head directly
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {s_record_key, s_record_payload};
                        count_next = cnt_inc;
                        if (s_batch_end) begin
                            state_next = ST_FETCH;
                        end
                    end else begin
                        // Start walking down from the tail
                        new_key_next  = s_record_key;
                        new_pay_next  = s_record_payload;
                        new_last_next = s_batch_end;
                        pos_next      = count_reg;
                        rd_en         = 1'b1;
                        rd_addr       = cnt_last[IDX_W-1:0];
                        state_next    = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                if (new_key_reg < rd_key) begin
                    // Move the larger entry up one slot, fetch the next one down
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[IDX_W-1:0];
                    wr_data  = rd_data;
                    pos_next = pos_dec;
                    if (pos_reg == CNT_W'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_dec2[IDX_W-1:0];
                    end
                end else begin
                    // Equal or smaller key stops the walk: place after it
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[IDX_W-1:0];
                    wr_data    = {new_key_reg, new_pay_reg};
                    count_next = cnt_inc;
                    state_next = new_last_reg ? ST_FETCH : ST_IDLE;
                end
            end

            ST_PLACE: begin
                // Land at the head of the store
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IDX_W-1:0];
                wr_data    = {new_key_reg, new_pay_reg};
                count_next = cnt_inc;
                state_next = new_last_reg ? ST_FETCH : ST_IDLE;
            end

            ST_FETCH: begin
                rd_en         = 1'b1;
                rd_addr       = '0;
                emit_idx_next = '0;
                state_next    = ST_LOAD;
            end

            ST_LOAD: begin
                // Present the first entry, prefetch the one after it
                m_valid_next = 1'b1;
                m_key_next   = rd_key;
                m_pay_next   = rd_pay;
                m_final_next = emit_is_final;
                m_ovf_next   = ovf_reg;
                if (!emit_is_final) begin
                    rd_en   = 1'b1;
                    rd_addr = emit_inc[IDX_W-1:0];
                end
                emit_idx_next = emit_inc;
                state_next    = ST_HOLD;
            end

            ST_HOLD: begin
                if (m_ready) begin
                    if (m_final_reg) begin
                        // Batch done: clear the store for the next one
                        m_valid_next = 1'b0;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        // Advance to the prefetched entry
                        m_key_next   = rd_key;
                        m_pay_next   = rd_pay;
                        m_final_next = emit_is_final;
                        if (!emit_is_final) begin
                            rd_en   = 1'b1;
                            rd_addr = emit_inc[IDX_W-1:0];
                        end
                        emit_idx_next = emit_inc;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg      <= pos_next;
        emit_idx_reg <= emit_idx_next;
        new_key_reg  <= new_key_next;
        new_pay_reg  <= new_pay_next;
        new_last_reg <= new_last_next;
        m_key_reg    <= m_key_next;
        m_pay_reg    <= m_pay_next;
        m_final_reg  <= m_final_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_sorted_key     = m_key_reg;
    assign m_sorted_payload = m_pay_reg;
    assign m_final_result   = m_final_reg;
    assign m_overflowed     = m_ovf_reg;

    // Intake and readout never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // Record count stays within capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    // Taking the final result empties the store and clears the overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_result) |=> (count_reg == '0 && !ovf_reg && s_ready))
        else $error("store not cleared after final result");

    // A walk step never writes above the tail of the batch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (pos_reg <= count_reg && pos_reg != '0))
        else $error("insertion position out of range");

endmodule : stable_record_sort_by_key

`default_nettype wire
